// File: design/lpc_pkg.sv
package lpc_pkg;

   localparam int unsigned SPRITE_IDX   = 4;
   localparam int unsigned BACKDROP_IDX = 5;
   localparam logic [4:0]  CH_MAX    = 5'd31;
   localparam logic [4:0]  W_MAX     = 5'd16;
   localparam logic [15:0] OPAQUE_BIT = 16'h8000;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_OFF      = 2'd0;
   localparam logic [1:0] MODE_ALPHA    = 2'd1;
   localparam logic [1:0] MODE_BRIGHTEN = 2'd2;
   localparam logic [1:0] MODE_DARKEN   = 2'd3;

   localparam logic [2:0] REG_LAYER_CONTROL  = 3'd0;
   localparam logic [2:0] REG_BG_PRIORITIES  = 3'd1;
   localparam logic [2:0] REG_WINDOW_INSIDE  = 3'd2;
   localparam logic [2:0] REG_WINDOW_OUTSIDE = 3'd3;
   localparam logic [2:0] REG_BLEND_CONTROL  = 3'd4;
   localparam logic [2:0] REG_BLEND_ALPHA    = 3'd5;
   localparam logic [2:0] REG_BRIGHTNESS     = 3'd6;
   localparam logic [2:0] REG_BACKDROP_COLOR = 3'd7;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_MIX,
      OP_LIGHTEN,
      OP_DIM
   } op_type;

   typedef struct packed {
      logic [8:0]  layer_control;
      logic [7:0]  bg_priorities;
      logic [11:0] window_inside;
      logic [11:0] window_outside;
      logic [13:0] blend_control;
      logic [9:0]  blend_alpha;
      logic [4:0]  brightness;
      logic [14:0] backdrop_color;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [14:0] top_color;
      logic [14:0] second_color;
      logic [4:0]  weight_a;
      logic [4:0]  weight_b;
   } item_type;

   function automatic logic [4:0] cap16(input logic [4:0] v);
      return (v > W_MAX) ? W_MAX : v;
   endfunction

endpackage

// File: design/lpc_front.sv
module lpc_front
   import lpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        accept,
   input  logic [14:0] bg0_color,
   input  logic [14:0] bg1_color,
   input  logic [14:0] bg2_color,
   input  logic [14:0] bg3_color,
   input  logic [3:0]  bg_opaque,
   input  logic [14:0] obj_color,
   input  logic        obj_opaque,
   input  logic [1:0]  obj_priority,
   input  logic        obj_semi_transparent,
   input  logic [2:0]  window_hits,
   input  logic [4:0]  bg0_3d_alpha,
   input  logic        push_ready,
   output logic        push_valid,
   output item_type    push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   logic [5:0]      mask;
   logic [3:0]      vis;
   logic [3:0][3:0] key;
   logic [3:0][1:0] rank;
   logic [2:0]      top, second, top_pri, second_pri;
   logic            alpha_obj, have_first, have_second, fx;
   logic [1:0]      mode;
   logic [5:0]      first_t, second_t;
   logic [4:0]      a3d;
   logic [14:0]     col [6];

   always_comb begin
      col[0] = bg0_color;
      col[1] = bg1_color;
      col[2] = bg2_color;
      col[3] = bg3_color;
      col[4] = obj_color;
      col[5] = cfg.backdrop_color;

      // win0 over win1 over sprite window, else the outside mask
      if (cfg.layer_control[7:5] == 3'd0) begin
         mask = 6'h3F;
      end else if (cfg.layer_control[5] && window_hits[0]) begin
         mask = cfg.window_inside[5:0];
      end else if (cfg.layer_control[6] && window_hits[1]) begin
         mask = cfg.window_inside[11:6];
      end else if (cfg.layer_control[7] && window_hits[2]) begin
         mask = cfg.window_outside[11:6];
      end else begin
         mask = cfg.window_outside[5:0];
      end

      for (int b = 0; b < 4; b++) begin
         vis[b] = cfg.layer_control[b] & mask[b] & bg_opaque[b];
         key[b] = {cfg.bg_priorities[2*b +: 2], 2'(b)};
      end
      // rank each background by how many visible ones sit above it
      for (int b = 0; b < 4; b++) begin
         rank[b] = 2'd0;
         for (int j = 0; j < 4; j++) begin
            if (j != b && vis[j] && key[j] < key[b]) rank[b] = rank[b] + 2'd1;
         end
      end

      top = 3'(BACKDROP_IDX);
      second = 3'(BACKDROP_IDX);
      top_pri = 3'd4;
      second_pri = 3'd4;
      for (int b = 0; b < 4; b++) begin
         if (vis[b] && rank[b] == 2'd0) begin
            top = 3'(b);
            top_pri = {1'b0, cfg.bg_priorities[2*b +: 2]};
         end
         if (vis[b] && rank[b] == 2'd1) begin
            second = 3'(b);
            second_pri = {1'b0, cfg.bg_priorities[2*b +: 2]};
         end
      end

      alpha_obj = 1'b0;
      if (mask[SPRITE_IDX] && cfg.layer_control[4] && obj_opaque) begin
         if ({1'b0, obj_priority} <= top_pri) begin
            second = top;
            top = 3'(SPRITE_IDX);
            alpha_obj = obj_semi_transparent;
         end else if ({1'b0, obj_priority} <= second_pri) begin
            second = 3'(SPRITE_IDX);
         end
      end

      mode = cfg.blend_control[1:0];
      first_t = cfg.blend_control[7:2];
      second_t = cfg.blend_control[13:8];
      have_first = first_t[top];
      have_second = second_t[second];
      fx = mask[5];
      a3d = cap16(bg0_3d_alpha);

      item_in.top_color = col[top];
      item_in.second_color = col[second];
      item_in.op = OP_NONE;
      item_in.weight_a = cap16(cfg.blend_alpha[4:0]);
      item_in.weight_b = cap16(cfg.blend_alpha[9:5]);

      if (alpha_obj && have_second) begin
         item_in.op = OP_MIX;
      end else if (mode == MODE_ALPHA) begin
         if (top == 3'd0 && cfg.layer_control[8] && have_second) begin
            item_in.op = OP_MIX;
            item_in.weight_a = a3d;
            item_in.weight_b = W_MAX - a3d;
         end else if (have_first && have_second && fx) begin
            item_in.op = OP_MIX;
         end
      end else if (mode != MODE_OFF && have_first && fx) begin
         item_in.op = (mode == MODE_BRIGHTEN) ? OP_LIGHTEN : OP_DIM;
         item_in.weight_a = cap16(cfg.brightness);
      end

      // hold while the queue is full
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// File: design/lpc_queue.sv
module lpc_queue
   import lpc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     empty,
   output logic     full,
   output item_type head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type          mem [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]       count_ff, count_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) mem[wr_ff] <= push_item;
   end

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PW+1)'(DEPTH));
   assign head  = mem[rd_ff];

endmodule

// File: design/lpc_back.sv
module lpc_back
   import lpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        valid,
   input  item_type    item,
   output logic        rsp_valid,
   output logic [15:0] rsp_color
);

   logic        valid_ff;
   logic [15:0] color_ff;
   logic [14:0] px;
   logic [4:0]  ca, cb;
   logic [9:0]  sum;
   logic [9:0]  prod;

   always_comb begin
      px = item.top_color;
      for (int s = 0; s < 3; s++) begin
         ca = item.top_color[5*s +: 5];
         cb = item.second_color[5*s +: 5];
         sum = '0;
         prod = '0;
         case (item.op)
            OP_MIX: begin
               sum = ({5'd0, ca} * {5'd0, item.weight_a})
                   + ({5'd0, cb} * {5'd0, item.weight_b});
               px[5*s +: 5] = (sum[9:4] > 6'(CH_MAX)) ? CH_MAX : sum[8:4];
            end
            OP_LIGHTEN: begin
               prod = {5'd0, CH_MAX - ca} * {5'd0, item.weight_a};
               px[5*s +: 5] = ca + prod[8:4];
            end
            OP_DIM: begin
               prod = {5'd0, ca} * {5'd0, item.weight_a};
               px[5*s +: 5] = ca - prod[8:4];
            end
            default: px[5*s +: 5] = ca;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
      color_ff <= {1'b0, px} | OPAQUE_BIT;
   end

   assign rsp_valid = valid_ff;
   assign rsp_color = color_ff;

endmodule

// File: design/layer_priority_pixel_compositor.sv
// Accepted words pass the front register, the queue, then the output register.
// Throughput: one pixel per clock; the blend stage drains the queue every cycle.
// Busy rises only if the two-entry queue is full, which the receiver cannot cause.
// Synchronous reset clears control and config registers only; no clearing pass.
module layer_priority_pixel_compositor
   import lpc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_write_data,
   input  logic        start,
   output logic        busy,
   input  logic [14:0] req_bg0_color,
   input  logic [14:0] req_bg1_color,
   input  logic [14:0] req_bg2_color,
   input  logic [14:0] req_bg3_color,
   input  logic [3:0]  req_bg_opaque,
   input  logic [14:0] req_obj_color,
   input  logic        req_obj_opaque,
   input  logic [1:0]  req_obj_priority,
   input  logic        req_obj_semi_transparent,
   input  logic [2:0]  req_window_hits,
   input  logic [4:0]  req_bg0_3d_alpha,
   output logic        rsp_valid,
   output logic [15:0] rsp_composed_color
);

   cfg_type  cfg_ff;
   logic     accept, push_valid, q_empty, q_full, push;
   item_type push_item, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LAYER_CONTROL:  cfg_ff.layer_control  <= csr_write_data[8:0];
            REG_BG_PRIORITIES:  cfg_ff.bg_priorities  <= csr_write_data[7:0];
            REG_WINDOW_INSIDE:  cfg_ff.window_inside  <= csr_write_data[11:0];
            REG_WINDOW_OUTSIDE: cfg_ff.window_outside <= csr_write_data[11:0];
            REG_BLEND_CONTROL:  cfg_ff.blend_control  <= csr_write_data[13:0];
            REG_BLEND_ALPHA:    cfg_ff.blend_alpha    <= csr_write_data[9:0];
            REG_BRIGHTNESS:     cfg_ff.brightness     <= csr_write_data[4:0];
            REG_BACKDROP_COLOR: cfg_ff.backdrop_color <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign push   = push_valid && !q_full;
   assign busy   = push_valid && q_full;
   assign accept = start && !busy;

   lpc_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .accept(accept),
      .bg0_color(req_bg0_color), .bg1_color(req_bg1_color),
      .bg2_color(req_bg2_color), .bg3_color(req_bg3_color),
      .bg_opaque(req_bg_opaque), .obj_color(req_obj_color),
      .obj_opaque(req_obj_opaque), .obj_priority(req_obj_priority),
      .obj_semi_transparent(req_obj_semi_transparent),
      .window_hits(req_window_hits), .bg0_3d_alpha(req_bg0_3d_alpha),
      .push_ready(!q_full), .push_valid(push_valid), .push_item(push_item)
   );

   lpc_queue #(.DEPTH(DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(!q_empty), .empty(q_empty), .full(q_full), .head(head)
   );

   lpc_back u_back (
      .clock(clock), .reset(reset), .valid(!q_empty), .item(head),
      .rsp_valid(rsp_valid), .rsp_color(rsp_composed_color)
   );

   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid) else $error("accepted word not delivered in time");
   a_opaque_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_composed_color[15]) else $error("opaque bit clear");
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      !q_empty |=> (rsp_valid && !busy)) else $error("queue stalled");

endmodule

// File: tb/testbench.sv
module testbench;
   import lpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LATENCY = 3;
   localparam int unsigned RANDOM_PIXELS = 1700;
   localparam int unsigned NUM_SETTINGS = 6;

   typedef struct {
      logic [14:0] bg_color [4];
      logic [3:0]  bg_opaque;
      logic [14:0] obj_color;
      logic        obj_opaque;
      logic [1:0]  obj_priority;
      logic        obj_semi;
      logic [2:0]  window_hits;
      logic [4:0]  alpha_3d;
   } pixel_type;

   typedef struct {
      pixel_type   pixel;
      logic        has_fixed;
      logic [15:0] fixed_color;
   } pixel_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [14:0] csr_write_data;
   logic        start;
   logic        busy;
   logic [14:0] req_bg0_color, req_bg1_color, req_bg2_color, req_bg3_color;
   logic [3:0]  req_bg_opaque;
   logic [14:0] req_obj_color;
   logic        req_obj_opaque;
   logic [1:0]  req_obj_priority;
   logic        req_obj_semi_transparent;
   logic [2:0]  req_window_hits;
   logic [4:0]  req_bg0_3d_alpha;
   logic        rsp_valid;
   logic [15:0] rsp_composed_color;

   cfg_type     shadow_cfg;
   logic [15:0] pending_colors [$];
   int unsigned mismatch_count;

   layer_priority_pixel_compositor dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[layer_priority_pixel_compositor] ERROR");
      $finish;
   end

   function automatic logic [4:0] clamp_weight(input logic [4:0] w);
      return (w > 5'd16) ? 5'd16 : w;
   endfunction

   function automatic logic [14:0] blend_colors(input logic [14:0] a, input logic [14:0] b,
                                                input logic [4:0] wa, input logic [4:0] wb);
      logic [14:0] out;
      int unsigned c;
      out = '0;
      for (int s = 0; s < 15; s += 5) begin
         c = (int'(a[s +: 5]) * clamp_weight(wa) + int'(b[s +: 5]) * clamp_weight(wb)) >> 4;
         if (c > 31) c = 31;
         out[s +: 5] = c[4:0];
      end
      return out;
   endfunction

   function automatic logic [14:0] shade_color(input logic [14:0] a, input logic [4:0] y,
                                               input logic brighten);
      logic [14:0] out;
      int unsigned c;
      int unsigned f;
      out = '0;
      f = clamp_weight(y);
      for (int s = 0; s < 15; s += 5) begin
         c = a[s +: 5];
         if (brighten) c = c + (((31 - c) * f) >> 4);
         else c = c - ((c * f) >> 4);
         out[s +: 5] = c[4:0];
      end
      return out;
   endfunction

   function automatic logic [15:0] compose_pixel(input pixel_type px, input cfg_type cfg);
      logic [14:0] colors [6];
      logic [5:0]  mask;
      int unsigned top, second, pri0, pri1, bp;
      logic [4:0]  a3d;
      logic [1:0]  mode;
      logic [5:0]  first_t, second_t;
      logic        obj_alpha, have_first, have_second, fx;
      logic [14:0] out;
      for (int b = 0; b < 4; b++) colors[b] = px.bg_color[b];
      colors[SPRITE_IDX] = px.obj_color;
      colors[BACKDROP_IDX] = cfg.backdrop_color;
      a3d = clamp_weight(px.alpha_3d);
      if (cfg.layer_control[7:5] == 3'b000) mask = 6'h3F;
      else if (cfg.layer_control[5] && px.window_hits[0]) mask = cfg.window_inside[5:0];
      else if (cfg.layer_control[6] && px.window_hits[1]) mask = cfg.window_inside[11:6];
      else if (cfg.layer_control[7] && px.window_hits[2]) mask = cfg.window_outside[11:6];
      else mask = cfg.window_outside[5:0];
      top = BACKDROP_IDX;
      second = BACKDROP_IDX;
      pri0 = 4;
      pri1 = 4;
      obj_alpha = 1'b0;
      // walk from the lowest priority up; each visible layer pushes the last one down
      for (int p = 3; p >= 0; p--) begin
         for (int b = 3; b >= 0; b--) begin
            bp = cfg.bg_priorities[2*b +: 2];
            if (cfg.layer_control[b] && bp == p && mask[b] && px.bg_opaque[b]) begin
               second = top;
               top = b;
               pri1 = pri0;
               pri0 = bp;
            end
         end
      end
      if (mask[SPRITE_IDX] && cfg.layer_control[4] && px.obj_opaque) begin
         if (px.obj_priority <= pri0) begin
            second = top;
            top = SPRITE_IDX;
            obj_alpha = px.obj_semi;
         end else if (px.obj_priority <= pri1) begin
            second = SPRITE_IDX;
         end
      end
      mode = cfg.blend_control[1:0];
      first_t = cfg.blend_control[7:2];
      second_t = cfg.blend_control[13:8];
      have_first = first_t[top];
      have_second = second_t[second];
      fx = mask[5];
      out = colors[top];
      if (obj_alpha && have_second) begin
         out = blend_colors(out, colors[second], cfg.blend_alpha[4:0], cfg.blend_alpha[9:5]);
      end else if (mode == MODE_ALPHA) begin
         if (top == 0 && cfg.layer_control[8] && have_second)
            out = blend_colors(out, colors[second], a3d, 5'd16 - a3d);
         else if (have_first && have_second && fx)
            out = blend_colors(out, colors[second], cfg.blend_alpha[4:0], cfg.blend_alpha[9:5]);
      end else if (mode != MODE_OFF && have_first && fx) begin
         out = shade_color(out, cfg.brightness, mode == MODE_BRIGHTEN);
      end
      return {1'b1, out};
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      for (int b = 0; b < 4; b++) px.bg_color[b] = 15'($urandom);
      px.bg_opaque = 4'($urandom);
      px.obj_color = 15'($urandom);
      px.obj_opaque = 1'($urandom);
      px.obj_priority = 2'($urandom);
      px.obj_semi = 1'($urandom);
      px.window_hits = 3'($urandom);
      px.alpha_3d = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
      return px;
   endfunction

   function automatic pixel_type flat_pixel(input logic [14:0] c, input logic [3:0] op,
                                            input logic oo, input logic [1:0] opri,
                                            input logic semi, input logic [2:0] hits,
                                            input logic [4:0] a3d);
      pixel_type px;
      for (int b = 0; b < 4; b++) px.bg_color[b] = c ^ 15'(b * 15'h0421);
      px.bg_opaque = op;
      px.obj_color = ~c;
      px.obj_opaque = oo;
      px.obj_priority = opri;
      px.obj_semi = semi;
      px.window_hits = hits;
      px.alpha_3d = a3d;
      return px;
   endfunction

   // the caller drops the write enable after the last register
   task automatic write_register(input logic [2:0] index, input logic [14:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      case (index)
         REG_LAYER_CONTROL:  shadow_cfg.layer_control  = value[8:0];
         REG_BG_PRIORITIES:  shadow_cfg.bg_priorities  = value[7:0];
         REG_WINDOW_INSIDE:  shadow_cfg.window_inside  = value[11:0];
         REG_WINDOW_OUTSIDE: shadow_cfg.window_outside = value[11:0];
         REG_BLEND_CONTROL:  shadow_cfg.blend_control  = value[13:0];
         REG_BLEND_ALPHA:    shadow_cfg.blend_alpha    = value[9:0];
         REG_BRIGHTNESS:     shadow_cfg.brightness     = value[4:0];
         default:            shadow_cfg.backdrop_color = value;
      endcase
   endtask

   // hold until every expected word is back, then let the pipe settle
   task automatic drain_pipe();
      start <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type px, input logic has_fixed,
                             input logic [15:0] fixed_color, input int unsigned gap);
      logic [15:0] want;
      if (gap != 0) start <= 1'b0;
      repeat (gap) @(posedge clock);
      req_bg0_color <= px.bg_color[0];
      req_bg1_color <= px.bg_color[1];
      req_bg2_color <= px.bg_color[2];
      req_bg3_color <= px.bg_color[3];
      req_bg_opaque <= px.bg_opaque;
      req_obj_color <= px.obj_color;
      req_obj_opaque <= px.obj_opaque;
      req_obj_priority <= px.obj_priority;
      req_obj_semi_transparent <= px.obj_semi;
      req_window_hits <= px.window_hits;
      req_bg0_3d_alpha <= px.alpha_3d;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = compose_pixel(px, shadow_cfg);
      if (has_fixed && want !== fixed_color)
         report_mismatch("directed row", want, fixed_color);
      pending_colors.push_back(has_fixed ? fixed_color : want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            report_mismatch("unexpected word", rsp_composed_color, 16'h0);
         end else begin
            if (rsp_composed_color !== pending_colors[0])
               report_mismatch("composed_color", rsp_composed_color, pending_colors[0]);
            void'(pending_colors.pop_front());
         end
      end
   end

   initial begin
      pixel_row_type rows [$];
      pixel_row_type row;
      int unsigned wait_cycles;
      logic [14:0] settings [NUM_SETTINGS][8];
      mismatch_count = 0;
      shadow_cfg = '0;
      reset = 1'b1;
      start = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_LAYER_CONTROL;
      csr_write_data = '0;
      req_bg0_color = '0;
      req_bg1_color = '0;
      req_bg2_color = '0;
      req_bg3_color = '0;
      req_bg_opaque = '0;
      req_obj_color = '0;
      req_obj_opaque = 1'b0;
      req_obj_priority = '0;
      req_obj_semi_transparent = 1'b0;
      req_window_hits = '0;
      req_bg0_3d_alpha = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every layer is off, so the zero backdrop shows
      row.has_fixed = 1'b1;
      row.fixed_color = OPAQUE_BIT;
      row.pixel = flat_pixel(15'h7FFF, 4'hF, 1'b1, 2'd0, 1'b1, 3'h7, 5'd31);
      rows.push_back(row);
      row.pixel = flat_pixel(15'h0000, 4'h0, 1'b0, 2'd3, 1'b0, 3'h0, 5'd0);
      rows.push_back(row);
      foreach (rows[i]) send_pixel(rows[i].pixel, rows[i].has_fixed, rows[i].fixed_color, 0);
      drain_pipe();

      // settings: plain, alpha with 3D, brighten, darken, windows, all-ones extremes
      settings[0] = '{15'h01F, 15'h0E4, 15'h000, 15'h000, 15'h0000, 15'h000, 15'd0,  15'h7C00};
      settings[1] = '{15'h11F, 15'h01B, 15'h000, 15'h000, 15'h3F7D, 15'h3FF, 15'd31, 15'h03E0};
      settings[2] = '{15'h01F, 15'h055, 15'h000, 15'h000, 15'h00FE, 15'h000, 15'd31, 15'h001F};
      settings[3] = '{15'h01F, 15'h0AA, 15'h000, 15'h000, 15'h00FF, 15'h000, 15'd8,  15'h7FFF};
      settings[4] = '{15'h1FF, 15'h0E4, 15'h9E5, 15'h5A7, 15'h3FF5, 15'h1A8, 15'd20, 15'h1234};
      settings[5] = '{15'h1FF, 15'h0FF, 15'hFFF, 15'hFFF, 15'h3FFF, 15'h3FF, 15'd31, 15'h7FFF};

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         for (int r = 0; r < 8; r++) write_register(3'(r), settings[s][r]);
         csr_write_enable <= 1'b0;
         rows.delete();
         row.has_fixed = 1'b0;
         row.fixed_color = '0;
         row.pixel = flat_pixel(15'h7FFF, 4'hF, 1'b1, 2'd0, 1'b1, 3'h1, 5'd16);
         rows.push_back(row);
         row.pixel = flat_pixel(15'h0000, 4'hF, 1'b1, 2'd3, 1'b0, 3'h2, 5'd31);
         rows.push_back(row);
         row.pixel = flat_pixel(15'h5555, 4'h1, 1'b0, 2'd2, 1'b0, 3'h4, 5'd0);
         rows.push_back(row);
         row.pixel = flat_pixel(15'h2AAA, 4'h0, 1'b1, 2'd1, 1'b1, 3'h0, 5'd8);
         rows.push_back(row);
         foreach (rows[i]) send_pixel(rows[i].pixel, 1'b0, '0, $urandom_range(0, 2));
         drain_pipe();
      end

      for (int k = 0; k < RANDOM_PIXELS; k++) begin
         if (k % 200 == 0) begin
            drain_pipe();
            for (int r = 0; r < 8; r++) write_register(3'(r), 15'($urandom));
            csr_write_enable <= 1'b0;
         end
         if (k % 100 == 50) begin
            // drop input pressure entirely until the pipe is empty
            drain_pipe();
         end
         wait_cycles = ((k / 150) % 2 == 0) ? 0 : $urandom_range(0, 12);
         send_pixel(random_pixel(), 1'b0, '0, wait_cycles);
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_colors.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_colors.size() == 0) begin
         $display("[layer_priority_pixel_compositor] OK");
      end else begin
         $display("[layer_priority_pixel_compositor] ERROR");
      end
      $finish;
   end

endmodule
